@@ rtl/core/point_in_polygon_test_macros.svh @@
// assertion macros used by point_in_polygon_test
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// condition holds at every edge out of reset
`define PIP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle implies consequence in the same cycle
`define PIP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition in one cycle implies consequence in the next cycle
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam int PIP_COORD_W   = 24;
  localparam int PIP_MAX_VERTS = 1024;
  localparam int PIP_ADDR_W    = $clog2(PIP_MAX_VERTS);
  localparam int PIP_CNT_W     = PIP_ADDR_W + 1;
  localparam int PIP_MIN_VERTS = 3;
  localparam int PIP_DIFF_W    = PIP_COORD_W + 1;
  localparam int PIP_PROD_W    = 2 * PIP_DIFF_W;

  // request kinds carried on in_tuser
  localparam logic PIP_REQ_WRITE = 1'b0;
  localparam logic PIP_REQ_QUERY = 1'b1;

  typedef logic signed [PIP_COORD_W-1:0] coord_t;
  typedef logic signed [PIP_DIFF_W-1:0]  diff_t;
  typedef logic signed [PIP_PROD_W-1:0]  prod_t;

  // one edge handed to the evaluation pipeline
  typedef struct packed {
    logic   vld;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } edge_req_t;

  // status back from the evaluation pipeline
  typedef struct packed {
    logic busy;
    logic toggle;
  } edge_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/point_in_polygon_test.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Point-in-polygon test by crossing parity. Vertex writes (in_tuser low) store one
// vertex into a 1024-entry on-chip memory and give no result. A query (in_tuser
// high) reads the first vertex_count vertices from that memory, one per cycle
// through its single read port, and feeds each edge, closing edge included, into
// a three-stage evaluation pipeline; a query with fewer than three vertices in use
// answers 0 without reading the memory. vertex_count is to be written on the cfg
// port only while idle; the block does not enforce this. Values above 1024 act as
// 1024. Entries below vertex_count must have been written before a query. The
// result waits in an output register, so writes are taken while it is pending.
module point_in_polygon_test
  import pip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transactions
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // vertex_index[9:0], coord_x[33:10], coord_y[57:34]
  input  wire logic        in_tuser,   // req_type[0]
  // result transactions
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // inside_res[0]
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data    // vertex_count[10:0]
);

  `include "point_in_polygon_test_macros.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_CLOSE = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  // payload fields
  logic [PIP_ADDR_W-1:0] in_idx;
  coord_t                in_x, in_y;
  logic                  in_acc;

  assign in_idx = in_tdata[9:0];
  assign in_x   = in_tdata[33:10];
  assign in_y   = in_tdata[57:34];
  assign in_acc = in_tvalid && in_tready;

  // configuration register
  logic [PIP_CNT_W-1:0] vcount_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_valid) begin
      vcount_r <= cfg_data;
    end
  end

  // control state
  logic [1:0]           state_r, state_nxt;
  logic [PIP_CNT_W-1:0] n_r, n_nxt;
  logic [PIP_CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic                 parity_r, parity_nxt;
  logic                 done_r, done_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_bit_r, out_bit_nxt;
  logic                 rd_en;
  logic                 rd_vld_r, rd_first_r;
  logic [PIP_CNT_W-1:0] n_clamped;
  edge_stat_t           eu_stat;
  edge_req_t            eu_req;

  assign n_clamped = (vcount_r > PIP_CNT_W'(PIP_MAX_VERTS)) ?
                     PIP_CNT_W'(PIP_MAX_VERTS) : vcount_r;
  assign rd_en     = (state_r == ST_RUN) && (rd_cnt_r != n_r);
  assign in_tready = (state_r == ST_IDLE) && !done_r;

  // vertex memory, one write and one registered read port
  logic [2*PIP_COORD_W-1:0] vmem [PIP_MAX_VERTS];
  logic [2*PIP_COORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == PIP_REQ_WRITE)) begin
      vmem[in_idx] <= {in_y, in_x};
    end
    if (rd_en) begin
      rd_data_r <= vmem[rd_cnt_r[PIP_ADDR_W-1:0]];
    end
  end

  // query point, first and previous vertex
  coord_t px_r, py_r;
  coord_t first_x_r, first_y_r, prev_x_r, prev_y_r;
  coord_t rd_x, rd_y;

  assign rd_x = rd_data_r[PIP_COORD_W-1:0];
  assign rd_y = rd_data_r[2*PIP_COORD_W-1:PIP_COORD_W];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_x;
      py_r <= in_y;
    end
    if (rd_vld_r) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
      if (rd_first_r) begin
        first_x_r <= rd_x;
        first_y_r <= rd_y;
      end
    end
  end

  // edge to evaluate: previous with current, or last with first
  always_comb begin
    eu_req.vld = (rd_vld_r && !rd_first_r) || (state_r == ST_CLOSE);
    eu_req.ax  = prev_x_r;
    eu_req.ay  = prev_y_r;
    eu_req.bx  = (state_r == ST_CLOSE) ? first_x_r : rd_x;
    eu_req.by  = (state_r == ST_CLOSE) ? first_y_r : rd_y;
  end

  pip_edge_unit u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .px    (px_r),
    .py    (py_r),
    .req   (eu_req),
    .stat  (eu_stat)
  );

  // sequencer and output register
  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    rd_cnt_nxt  = rd_cnt_r;
    parity_nxt  = parity_r ^ eu_stat.toggle;
    done_nxt    = done_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_bit_nxt = out_bit_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == PIP_REQ_QUERY)) begin
          n_nxt      = n_clamped;
          rd_cnt_nxt = '0;
          parity_nxt = 1'b0;
          if (n_clamped < PIP_CNT_W'(PIP_MIN_VERTS)) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + PIP_CNT_W'(1);
        end else begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!eu_stat.busy) begin
          state_nxt = ST_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // hand the answer over once the output register is free
    if (done_r && (!out_vld_r || out_tready)) begin
      done_nxt    = 1'b0;
      out_vld_nxt = 1'b1;
      out_bit_nxt = parity_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      done_r     <= 1'b0;
      out_vld_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      done_r     <= done_nxt;
      out_vld_r  <= out_vld_nxt;
      rd_vld_r   <= rd_en;
      rd_first_r <= rd_en && (rd_cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    parity_r  <= parity_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_bit_r};

  // checks
  logic u_edge_busy_chk;
  assign u_edge_busy_chk = eu_stat.busy || !eu_req.vld;

  `PIP_ASSERT_IMPL(a_idle_pipe_empty, in_tready, !eu_stat.busy, "edge pipeline busy while idle")
  `PIP_ASSERT_IMPL(a_read_in_range, rd_en, (rd_cnt_r < n_r) && (n_r >= PIP_CNT_W'(PIP_MIN_VERTS)), "vertex read beyond count")
  `PIP_ASSERT_NEXT(a_close_once, state_r == ST_CLOSE, state_r == ST_DRAIN && u_edge_busy_chk, "closing edge not issued")
  `PIP_ASSERT_ALWAYS(a_done_quiet, !done_r || (!eu_stat.busy && state_r == ST_IDLE), "answer ready with edges in flight")

endmodule

`default_nettype wire

@@ rtl/core/pip_edge_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_edge_unit
  import pip_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire coord_t     px,
  input  wire coord_t     py,
  input  wire edge_req_t  req,
  output edge_stat_t      stat
);

  // stage 1: order the ends by x, span test and differences
  coord_t ax, ay, bx, by;
  coord_t lox, loy, hix, hiy;
  logic   swap;
  logic   s1_vld_r, s1_vld_nxt;
  diff_t  s1_dyl_r, s1_dx_r, s1_dyr_r, s1_dxp_r;

  always_comb begin
    ax   = req.ax;
    ay   = req.ay;
    bx   = req.bx;
    by   = req.by;
    swap = ax > bx;
    lox  = swap ? bx : ax;
    loy  = swap ? by : ay;
    hix  = swap ? ax : bx;
    hiy  = swap ? ay : by;
    s1_vld_nxt = req.vld && (px >= lox) && (px < hix);
  end

  always_ff @(posedge clk) begin
    s1_dyl_r <= diff_t'(py) - diff_t'(loy);
    s1_dx_r  <= diff_t'(hix) - diff_t'(lox);
    s1_dyr_r <= diff_t'(hiy) - diff_t'(loy);
    s1_dxp_r <= diff_t'(px) - diff_t'(lox);
  end

  // stage 2: both cross products
  logic  s2_vld_r;
  prod_t s2_pl_r, s2_pr_r;

  always_ff @(posedge clk) begin
    s2_pl_r <= prod_t'(s1_dyl_r) * prod_t'(s1_dx_r);
    s2_pr_r <= prod_t'(s1_dyr_r) * prod_t'(s1_dxp_r);
  end

  // stage 3: point below the edge line toggles parity
  logic s3_tgl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_tgl_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r;
      s3_tgl_r <= s2_vld_r && (s2_pl_r < s2_pr_r);
    end
  end

  assign stat.busy   = s1_vld_r || s2_vld_r || s3_tgl_r;
  assign stat.toggle = s3_tgl_r;

endmodule

`default_nettype wire
